>>> hw/rtl/etl_pkg.sv
// ----------------------------------------------------------------------------
// etl_pkg
// Shared types, token codes and character classes for the expression lexer.
// ----------------------------------------------------------------------------
package etl_pkg;

    localparam int CHAR_W = 8;
    localparam int TYPE_W = 5;

    localparam logic [TYPE_W-1:0] TT_ERROR    = 5'd0;
    localparam logic [TYPE_W-1:0] TT_END      = 5'd1;
    localparam logic [TYPE_W-1:0] TT_PLUS     = 5'd2;
    localparam logic [TYPE_W-1:0] TT_MINUS    = 5'd3;
    localparam logic [TYPE_W-1:0] TT_STAR     = 5'd4;
    localparam logic [TYPE_W-1:0] TT_SLASH    = 5'd5;
    localparam logic [TYPE_W-1:0] TT_EQUALS   = 5'd6;
    localparam logic [TYPE_W-1:0] TT_LPAREN   = 5'd7;
    localparam logic [TYPE_W-1:0] TT_RPAREN   = 5'd8;
    localparam logic [TYPE_W-1:0] TT_LBRACKET = 5'd9;
    localparam logic [TYPE_W-1:0] TT_RBRACKET = 5'd10;
    localparam logic [TYPE_W-1:0] TT_LBRACE   = 5'd11;
    localparam logic [TYPE_W-1:0] TT_RBRACE   = 5'd12;
    localparam logic [TYPE_W-1:0] TT_INT      = 5'd13;
    localparam logic [TYPE_W-1:0] TT_HEX      = 5'd14;
    localparam logic [TYPE_W-1:0] TT_FLOAT    = 5'd15;
    localparam logic [TYPE_W-1:0] TT_HEXFLOAT = 5'd16;
    localparam logic [TYPE_W-1:0] TT_IDENT    = 5'd17;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        MODE_DEFAULT = 2'd0,
        MODE_NUMBER  = 2'd1,
        MODE_IDENT   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        NK_INT      = 2'd0,
        NK_HEX      = 2'd1,
        NK_FLOAT    = 2'd2,
        NK_HEXFLOAT = 2'd3
    } t_num_kind;

    typedef struct packed {
        t_mode      mode;
        t_num_kind  num_kind;
        logic       first_was_zero;
        logic [1:0] chars_in_number;
    } t_lex_state;

    typedef struct packed {
        logic              kind;
        logic [TYPE_W-1:0] token_type;
        logic [CHAR_W-1:0] char_value;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res       res0;
        t_res       res1;
    } t_lex_out;

    function automatic logic f_is_digit(logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic f_is_alpha(logic [CHAR_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic f_is_xdigit(logic [CHAR_W-1:0] c);
        return f_is_digit(c) || ((c >= 8'h41) && (c <= 8'h46))
            || ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic f_is_space(logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [TYPE_W-1:0] f_symbol_type(logic [CHAR_W-1:0] c);
        logic [TYPE_W-1:0] t;
        case (c)
            8'h2B: t = TT_PLUS;
            8'h2D: t = TT_MINUS;
            8'h2A: t = TT_STAR;
            8'h2F: t = TT_SLASH;
            8'h3D: t = TT_EQUALS;
            8'h28: t = TT_LPAREN;
            8'h29: t = TT_RPAREN;
            8'h5B: t = TT_LBRACKET;
            8'h5D: t = TT_RBRACKET;
            8'h7B: t = TT_LBRACE;
            8'h7D: t = TT_RBRACE;
            default: t = TT_ERROR;
        endcase
        return t;
    endfunction

endpackage

>>> hw/rtl/etl_lex.sv
// ----------------------------------------------------------------------------
// etl_lex
// Lexer state registers and the single-pass step logic for one byte.
// ----------------------------------------------------------------------------
module etl_lex import etl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [CHAR_W-1:0] i_char,
    output t_lex_out          o_lex
);

    t_lex_state        r_state;
    t_lex_state        n_state;
    t_lex_state        w_def_state;
    t_res              w_def_res;
    logic              w_def_has;
    logic [TYPE_W-1:0] w_num_type;
    logic [1:0]        w_count_inc;

    // default-mode lexing of the current byte, used directly or after a token ends
    always_comb begin
        w_def_state      = r_state;
        w_def_state.mode = MODE_DEFAULT;
        w_def_has        = 1'b1;
        w_def_res        = '0;
        if (f_is_space(i_char)) begin
            w_def_has = 1'b0;
        end else if (f_is_digit(i_char)) begin
            w_def_state.mode            = MODE_NUMBER;
            w_def_state.num_kind        = NK_INT;
            w_def_state.first_was_zero  = (i_char == CH_ZERO);
            w_def_state.chars_in_number = 2'd1;
            w_def_res = '{kind: 1'b0, token_type: TT_INT, char_value: i_char};
        end else if (f_is_alpha(i_char)) begin
            w_def_state.mode = MODE_IDENT;
            w_def_res = '{kind: 1'b0, token_type: TT_IDENT, char_value: i_char};
        end else if (f_symbol_type(i_char) != TT_ERROR) begin
            w_def_res = '{kind: 1'b1, token_type: f_symbol_type(i_char),
                          char_value: CH_NUL};
        end else if (i_char == CH_NUL) begin
            w_def_res = '{kind: 1'b1, token_type: TT_END, char_value: CH_NUL};
        end else begin
            w_def_res = '{kind: 1'b1, token_type: TT_ERROR, char_value: i_char};
        end
    end

    assign w_num_type  = TT_INT + {3'b000, r_state.num_kind};
    assign w_count_inc = (r_state.chars_in_number == 2'd2) ? 2'd2
                                                            : r_state.chars_in_number + 2'd1;

    always_comb begin
        n_state   = r_state;
        o_lex     = '0;
        case (r_state.mode)
            MODE_NUMBER: begin
                if (f_is_digit(i_char) || (r_state.num_kind[0] && f_is_xdigit(i_char))) begin
                    n_state.chars_in_number = w_count_inc;
                    o_lex.cnt  = 2'd1;
                    o_lex.res0 = '{kind: 1'b0, token_type: w_num_type, char_value: i_char};
                end else if (((i_char == CH_LOW_X) || (i_char == CH_UP_X))
                             && r_state.first_was_zero
                             && (r_state.chars_in_number == 2'd1)) begin
                    n_state.chars_in_number = w_count_inc;
                    n_state.num_kind        = NK_HEX;
                    o_lex.cnt  = 2'd1;
                    o_lex.res0 = '{kind: 1'b0, token_type: TT_HEX, char_value: i_char};
                end else if ((i_char == CH_POINT) && !r_state.num_kind[1]) begin
                    n_state.chars_in_number = w_count_inc;
                    n_state.num_kind = r_state.num_kind[0] ? NK_HEXFLOAT : NK_FLOAT;
                    o_lex.cnt  = 2'd1;
                    o_lex.res0 = '{kind: 1'b0,
                                   token_type: r_state.num_kind[0] ? TT_HEXFLOAT : TT_FLOAT,
                                   char_value: i_char};
                end else if (i_char == CH_COMMA) begin
                    n_state.chars_in_number = w_count_inc;
                end else begin
                    n_state    = w_def_state;
                    o_lex.res0 = '{kind: 1'b1, token_type: w_num_type, char_value: CH_NUL};
                    o_lex.res1 = w_def_res;
                    o_lex.cnt  = w_def_has ? 2'd2 : 2'd1;
                end
            end
            MODE_IDENT: begin
                if (f_is_alpha(i_char) || (i_char == CH_UNDER)) begin
                    o_lex.cnt  = 2'd1;
                    o_lex.res0 = '{kind: 1'b0, token_type: TT_IDENT, char_value: i_char};
                end else begin
                    n_state    = w_def_state;
                    o_lex.res0 = '{kind: 1'b1, token_type: TT_IDENT, char_value: CH_NUL};
                    o_lex.res1 = w_def_res;
                    o_lex.cnt  = w_def_has ? 2'd2 : 2'd1;
                end
            end
            default: begin
                n_state    = w_def_state;
                o_lex.res0 = w_def_res;
                o_lex.cnt  = w_def_has ? 2'd1 : 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode            <= MODE_DEFAULT;
            r_state.num_kind        <= NK_INT;
            r_state.first_was_zero  <= 1'b0;
            r_state.chars_in_number <= 2'd0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/etl_out.sv
// ----------------------------------------------------------------------------
// etl_out
// Result register holding the results of one byte, shown one per cycle unless i_ready stalls.
// ----------------------------------------------------------------------------
module etl_out import etl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_lex_out i_lex,
    input  logic     i_ready,
    output logic     o_can_load,
    output logic     o_valid,
    output t_res     o_res,
    output logic     o_last
);

    logic r_valid;
    logic r_two;
    logic r_sel;
    t_res r_res0;
    t_res r_res1;

    assign o_valid    = r_valid;
    assign o_res      = r_sel ? r_res1 : r_res0;
    assign o_last     = r_sel || !r_two;
    assign o_can_load = !r_valid || (i_ready && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_two   <= 1'b0;
            r_sel   <= 1'b0;
        end else if (i_load) begin
            r_valid <= (i_lex.cnt != 2'd0);
            r_two   <= (i_lex.cnt == 2'd2);
            r_sel   <= 1'b0;
        end else if (r_valid && i_ready) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res0 <= i_lex.res0;
            r_res1 <= i_lex.res1;
        end
    end

endmodule

>>> hw/rtl/expression_token_lexer.sv
// ----------------------------------------------------------------------------
// expression_token_lexer
// Byte-stream lexer for arithmetic expressions with streamed token text.
// ----------------------------------------------------------------------------
// Each byte is taken into an input register, lexed combinationally and its
// results (none, one or two) are placed in a result register that shows them
// one per cycle unless i_ready stalls, with o_last marking the final result of
// the byte. A byte that gives at most one result sustains one byte per cycle
// while i_ready is high. A byte that ends a token and starts another gives two
// results, and the next byte waits for both to pass the single result port.
// No clearing pass follows reset.
module expression_token_lexer import etl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_char_in,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [TYPE_W-1:0] o_token_type,
    output logic [CHAR_W-1:0] o_char_value,
    output logic              o_last
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              w_load;
    logic              w_can_load;
    t_lex_out          w_lex;
    t_res              w_res;

    assign w_load  = r_in_valid && w_can_load;
    assign o_ready = !r_in_valid || w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_char <= i_char_in;
        end
    end

    etl_lex u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_load),
        .i_char  (r_in_char),
        .o_lex   (w_lex)
    );

    etl_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_lex      (w_lex),
        .i_ready    (i_ready),
        .o_can_load (w_can_load),
        .o_valid    (o_valid),
        .o_res      (w_res),
        .o_last     (o_last)
    );

    assign o_kind       = w_res.kind;
    assign o_token_type = w_res.token_type;
    assign o_char_value = w_res.char_value;

endmodule

>>> hw/rtl/etl_chk.sv
// ----------------------------------------------------------------------------
// etl_chk
// Port-level checks on the lexer result stream, bound to the top level.
// ----------------------------------------------------------------------------
module etl_chk import etl_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_kind,
    input logic [TYPE_W-1:0] o_token_type,
    input logic [CHAR_W-1:0] o_char_value,
    input logic              o_last
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_kind, o_token_type, o_char_value, o_last}))
        else $error("result changed while stalled");

    a_type_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_token_type <= TT_IDENT)
        else $error("token type out of range");

    // value characters only belong to literals and identifiers
    a_value_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_token_type >= TT_INT)
        else $error("value character with symbol type");

    // completed tokens carry a byte only when they are errors
    a_done_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind && (o_token_type != TT_ERROR) |-> o_char_value == CH_NUL)
        else $error("completed token carries a byte");

    // a non-final result is always a completed literal or identifier
    a_first_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_kind && o_token_type >= TT_INT)
        else $error("unexpected first of two results");

endmodule

bind expression_token_lexer etl_chk u_etl_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_kind       (o_kind),
    .o_token_type (o_token_type),
    .o_char_value (o_char_value),
    .o_last       (o_last)
);

>>> tb/expression_token_lexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_token_lexer_tb
// Self-checking bench for the byte-stream expression lexer. Directed bytes
// cover every symbol, end of input, error bytes, whitespace and the number
// forms. Random expression text follows, mostly well-formed tokens and some
// noise bytes, in runs with and without random stall bursts on both channels.
// A token predictor in the bench works out the results of each byte, and each
// result transfer is compared against the oldest expected result.
// ----------------------------------------------------------------------------
module expression_token_lexer_tb;
    import etl_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic              kind;
        logic [TYPE_W-1:0] ttype;
        logic [CHAR_W-1:0] chv;
        logic              is_last;
    } t_token_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [CHAR_W-1:0] i_char_in = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_kind;
    logic [TYPE_W-1:0] o_token_type;
    logic [CHAR_W-1:0] o_char_value;
    logic              o_last;

    t_token_beat token_beats_due[$];
    t_token_beat step_beats[$];

    t_mode       lex_mode;
    t_num_kind   lit_kind;
    logic        lit_zero;
    logic [1:0]  lit_len;

    int n_fail = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit src_idle_on = 1'b0;
    bit sink_idle_on = 1'b0;

    string sym_alphabet = "+-*/=()[]{}";
    string num_alphabet = "0123456789abcdefABCDEF0123456789,.xX";
    string id_alphabet  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ__";

    expression_token_lexer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_in    (i_char_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_token_type (o_token_type),
        .o_char_value (o_char_value),
        .o_last       (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void emit_beat(logic kind, logic [TYPE_W-1:0] ttype,
                                      logic [CHAR_W-1:0] chv);
        t_token_beat b;
        b.kind    = kind;
        b.ttype   = ttype;
        b.chv     = chv;
        b.is_last = 1'b0;
        step_beats.push_back(b);
    endfunction

    function automatic void lex_plain(logic [CHAR_W-1:0] c);
        lex_mode = MODE_DEFAULT;
        if (!(c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D))) begin
            if (c >= "0" && c <= "9") begin
                lex_mode = MODE_NUMBER;
                lit_kind = NK_INT;
                lit_zero = (c == CH_ZERO);
                lit_len  = 2'd1;
                emit_beat(1'b0, TT_INT, c);
            end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
                lex_mode = MODE_IDENT;
                emit_beat(1'b0, TT_IDENT, c);
            end else begin
                case (c)
                    "+":     emit_beat(1'b1, TT_PLUS, '0);
                    "-":     emit_beat(1'b1, TT_MINUS, '0);
                    "*":     emit_beat(1'b1, TT_STAR, '0);
                    "/":     emit_beat(1'b1, TT_SLASH, '0);
                    "=":     emit_beat(1'b1, TT_EQUALS, '0);
                    "(":     emit_beat(1'b1, TT_LPAREN, '0);
                    ")":     emit_beat(1'b1, TT_RPAREN, '0);
                    "[":     emit_beat(1'b1, TT_LBRACKET, '0);
                    "]":     emit_beat(1'b1, TT_RBRACKET, '0);
                    "{":     emit_beat(1'b1, TT_LBRACE, '0);
                    "}":     emit_beat(1'b1, TT_RBRACE, '0);
                    CH_NUL:  emit_beat(1'b1, TT_END, '0);
                    default: emit_beat(1'b1, TT_ERROR, c);
                endcase
            end
        end
    endfunction

    function automatic void lex_number(logic [CHAR_W-1:0] c);
        logic [TYPE_W-1:0] cur;
        logic              hexish;
        logic              dec;
        logic              hexdig;
        logic [1:0]        next_len;
        cur      = TT_INT + {3'b000, lit_kind};
        hexish   = (lit_kind == NK_HEX) || (lit_kind == NK_HEXFLOAT);
        dec      = (c >= "0" && c <= "9");
        hexdig   = dec || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
        next_len = (lit_len == 2'd2) ? 2'd2 : lit_len + 2'd1;
        if (dec || (hexish && hexdig)) begin
            lit_len = next_len;
            emit_beat(1'b0, cur, c);
        end else if ((c == CH_LOW_X || c == CH_UP_X) && lit_zero && lit_len == 2'd1) begin
            lit_len  = next_len;
            lit_kind = NK_HEX;
            emit_beat(1'b0, TT_HEX, c);
        end else if (c == CH_POINT && (lit_kind == NK_INT || lit_kind == NK_HEX)) begin
            lit_len  = next_len;
            lit_kind = hexish ? NK_HEXFLOAT : NK_FLOAT;
            emit_beat(1'b0, hexish ? TT_HEXFLOAT : TT_FLOAT, c);
        end else if (c == CH_COMMA) begin
            lit_len = next_len;
        end else begin
            emit_beat(1'b1, cur, '0);
            lex_plain(c);
        end
    endfunction

    function automatic void tokenize_char(logic [CHAR_W-1:0] c);
        t_token_beat b;
        step_beats.delete();
        case (lex_mode)
            MODE_NUMBER: lex_number(c);
            MODE_IDENT: begin
                if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER) begin
                    emit_beat(1'b0, TT_IDENT, c);
                end else begin
                    emit_beat(1'b1, TT_IDENT, '0);
                    lex_plain(c);
                end
            end
            default: lex_plain(c);
        endcase
        if (step_beats.size() != 0) begin
            b = step_beats.pop_back();
            b.is_last = 1'b1;
            step_beats.push_back(b);
        end
        foreach (step_beats[k]) token_beats_due.push_back(step_beats[k]);
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c);
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tokenize_char(c);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k]);
    endtask

    task automatic test_symbols_and_end;
        send_text(sym_alphabet);
        send_char(CH_NUL);
    endtask

    task automatic test_error_and_space_bytes;
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h0B);
        send_char(8'h01);
    endtask

    task automatic test_number_forms;
        // hex prefix, hex float, second point, comma, x ending a number
        send_text("0X1.f.");
        send_text("7,x_ ");
    endtask

    task automatic test_random_expressions(input int n_items, input bit with_idle);
        logic [CHAR_W-1:0] text[$];
        int sent;
        int pick;
        int len;
        src_idle_on  = with_idle;
        sink_idle_on = with_idle;
        sent = 0;
        while (sent < n_items) begin
            text.delete();
            pick = $urandom_range(0, 19);
            if (pick < 6) begin
                if ($urandom_range(0, 2) == 0) begin
                    text.push_back(CH_ZERO);
                    text.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
                end else if ($urandom_range(0, 3) == 0) begin
                    text.push_back(CH_ZERO);
                end else begin
                    text.push_back(8'($urandom_range(8'h31, 8'h39)));
                end
                len = $urandom_range(0, 6);
                for (int j = 0; j < len; j++)
                    text.push_back(num_alphabet[$urandom_range(0, num_alphabet.len() - 1)]);
            end else if (pick < 10) begin
                text.push_back(id_alphabet[$urandom_range(0, 51)]);
                len = $urandom_range(0, 6);
                for (int j = 0; j < len; j++)
                    text.push_back(id_alphabet[$urandom_range(0, id_alphabet.len() - 1)]);
            end else if (pick < 15) begin
                text.push_back(sym_alphabet[$urandom_range(0, sym_alphabet.len() - 1)]);
            end else if (pick < 17) begin
                text.push_back($urandom_range(0, 5) == 0 ? CH_SPACE
                                                        : 8'($urandom_range(9, 13)));
            end else if (pick == 17) begin
                text.push_back(CH_NUL);
            end else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
            foreach (text[j]) send_char(text[j]);
            sent += text.size();
        end
    endtask

    // result side stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_token_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (token_beats_due.size() == 0) begin
                $error("unexpected result transfer: kind %0d token_type %0d char_value %0d",
                       o_kind, o_token_type, o_char_value);
                n_fail++;
            end else begin
                want = token_beats_due.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, o_kind);
                    n_fail++;
                end
                if (o_token_type !== want.ttype) begin
                    $error("token_type: expected %0d, actual %0d", want.ttype, o_token_type);
                    n_fail++;
                end
                if (o_char_value !== want.chv) begin
                    $error("char_value: expected %0d, actual %0d", want.chv, o_char_value);
                    n_fail++;
                end
                if (o_last !== want.is_last) begin
                    $error("last: expected %0d, actual %0d", want.is_last, o_last);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("expression_token_lexer: mismatch");
            $finish;
        end
    end

    initial begin
        lex_mode = MODE_DEFAULT;
        lit_kind = NK_INT;
        lit_zero = 1'b0;
        lit_len  = 2'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        test_symbols_and_end();
        test_error_and_space_bytes();
        test_number_forms();
        test_random_expressions(500, 1'b1);
        test_random_expressions(200, 1'b0);
        test_random_expressions(350, 1'b1);
        test_random_expressions(150, 1'b0);

        i_valid <= 1'b0;
        while (token_beats_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0)
            $display("expression_token_lexer: match");
        else
            $display("expression_token_lexer: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/etl_pkg.sv
hw/rtl/etl_lex.sv
hw/rtl/etl_out.sv
hw/rtl/expression_token_lexer.sv
hw/rtl/etl_chk.sv
tb/expression_token_lexer_tb.sv
